>>> rtl/core/skaf_pkg.sv
package skaf_pkg;

  localparam int VAR_W      = 32;
  localparam int DT_W       = 32;
  localparam int GAIN_W     = 25;
  localparam int FRAC_W     = 24;
  localparam int OPB_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // divider: (p << 24) + s/2 over s
  localparam int NUM_W      = VAR_W + FRAC_W + 1;
  localparam int DEN_W      = VAR_W + 1;
  localparam int DIV_CNT_W  = $clog2(GAIN_W + 1);

  localparam logic [GAIN_W-1:0] ONE_Q24 = 25'd16777216;

  localparam logic [CFG_IDX_W-1:0] REG_MODE              = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd2;

  localparam logic [VAR_W-1:0] PROCESS_NOISE_RST     = 32'd16777;
  localparam logic [VAR_W-1:0] MEASUREMENT_NOISE_RST = 32'd503316;
  localparam logic [VAR_W-1:0] COVARIANCE_RST        = 32'd16777216;

  typedef struct packed {
    logic load_in;
    logic mul_rate;
    logic cap_rate;
    logic pred;
    logic cap_q;
    logic resid;
    logic div_start;
    logic cap_gain;
    logic mul_corr;
    logic cap_corr;
    logic corr;
    logic cap_cov;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } stat_t;

endpackage

>>> rtl/core/skaf_mul.sv
module skaf_mul #(
  parameter int A_W = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [A_W-1:0]                    a,
  input  logic [skaf_pkg::OPB_W-1:0]        b,
  output logic                              done,
  output logic [A_W+skaf_pkg::OPB_W-1:0]    prod
);
  import skaf_pkg::*;

  localparam int NCH   = (A_W + OPB_W - 1) / OPB_W;
  localparam int PAD   = NCH * OPB_W;
  localparam int ACC_W = PAD + OPB_W;
  localparam int CW    = $clog2(NCH + 1);

  logic [PAD-1:0]     a_sh;
  logic [OPB_W-1:0]   b_reg;
  logic [2*OPB_W-1:0] pp;
  logic               pp_vld;
  logic [CW-1:0]      cnt;
  logic [ACC_W-1:0]   acc;

  // one 32x32 partial product per cycle, high chunk first
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= pp_vld && (cnt == '0);
      pp_vld <= !start && (cnt != '0);
      if (start) begin
        cnt <= CW'(NCH);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= PAD'(a);
      b_reg <= b;
      acc   <= '0;
    end else begin
      if (cnt != '0) begin
        pp   <= a_sh[PAD-1 -: OPB_W] * b_reg;
        a_sh <= a_sh << OPB_W;
      end
      if (pp_vld) begin
        acc <= (acc << OPB_W) + ACC_W'(pp);
      end
    end
  end

  assign prod = acc[A_W+OPB_W-1:0];

endmodule

>>> rtl/core/skaf_div.sv
module skaf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [skaf_pkg::NUM_W-1:0]    num,
  input  logic [skaf_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [skaf_pkg::GAIN_W-1:0]   quo
);
  import skaf_pkg::*;

  logic [DEN_W-1:0]     rem;
  logic [GAIN_W-1:0]    num_sh;
  logic [DEN_W-1:0]     den_reg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W:0]       rem2;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign rem2 = {rem, num_sh[GAIN_W-1]};
  assign diff = rem2 - {1'b0, den_reg};
  assign ge   = rem2 >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1));
      if (start) begin
        cnt <= DIV_CNT_W'(GAIN_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // restoring, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= DEN_W'(num[NUM_W-1:GAIN_W]);
      num_sh  <= num[GAIN_W-1:0];
      den_reg <= den;
    end else if (cnt != '0) begin
      rem    <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      num_sh <= num_sh << 1;
      quo    <= {quo[GAIN_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/skaf_dp.sv
module skaf_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  skaf_pkg::cmd_t                       cmd,
  output skaf_pkg::stat_t                      stat,
  input  logic                                 cfg_we,
  input  logic [skaf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skaf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [DATA_WIDTH-1:0]         measurement,
  input  logic signed [DATA_WIDTH-1:0]         control_rate,
  input  logic [skaf_pkg::DT_W-1:0]            time_step,
  output logic signed [DATA_WIDTH-1:0]         estimate_out,
  output logic [skaf_pkg::GAIN_W-1:0]          gain_out,
  output logic [skaf_pkg::VAR_W-1:0]           covariance_out,
  output logic signed [DATA_WIDTH-1:0]         residual_out
);
  import skaf_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int AW = (DW > OPB_W) ? DW : OPB_W;
  localparam int PW = AW + OPB_W;
  localparam int TW = PW - FRAC_W;
  localparam int SW = TW + 2;

  logic                  mode;
  logic [VAR_W-1:0]      process_noise;
  logic [VAR_W-1:0]      measurement_noise;

  logic signed [DW-1:0]  est;
  logic [VAR_W-1:0]      cov;
  logic signed [DW-1:0]  meas;
  logic signed [DW-1:0]  rate;
  logic [DT_W-1:0]       dt;
  logic [VAR_W-1:0]      p;
  logic signed [DW-1:0]  y;
  logic [DEN_W-1:0]      s;
  logic [GAIN_W-1:0]     gain;
  logic [TW-1:0]         tmp;

  logic [DW-1:0]         rate_mag;
  logic [DW-1:0]         y_mag;
  logic [AW-1:0]         mul_a;
  logic [OPB_W-1:0]      mul_b;
  logic                  mul_start;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         rnd32;
  logic [PW-1:0]         rnd24;
  logic [VAR_W:0]        p_sum;
  logic [VAR_W-1:0]      p_new;
  logic [VAR_W-1:0]      cov_new;
  logic signed [SW-1:0]  est_x;
  logic signed [SW-1:0]  tmp_s;
  logic signed [SW-1:0]  est_sum;
  logic signed [SW-1:0]  y_diff;
  logic                  sub;
  logic [NUM_W-1:0]      div_num;
  logic [GAIN_W-1:0]     quo;
  logic [GAIN_W-1:0]     gain_new;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
    if ((&v[SW-1:DW-1]) || !(|v[SW-1:DW-1])) begin
      return v[DW-1:0];
    end
    return {v[SW-1], {(DW-1){~v[SW-1]}}};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= 1'b0;
      process_noise     <= PROCESS_NOISE_RST;
      measurement_noise <= MEASUREMENT_NOISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:              mode              <= cfg_data[0];
        REG_PROCESS_NOISE:     process_noise     <= cfg_data[VAR_W-1:0];
        REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data[VAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign rate_mag = rate[DW-1] ? $unsigned(-rate) : $unsigned(rate);
  assign y_mag    = y[DW-1] ? $unsigned(-y) : $unsigned(y);

  always_comb begin
    mul_a = AW'(rate_mag);
    mul_b = dt;
    if (cmd.pred) begin
      mul_a = AW'(process_noise);
      mul_b = dt;
    end else if (cmd.mul_corr) begin
      mul_a = AW'(y_mag);
      mul_b = OPB_W'(gain);
    end else if (cmd.corr) begin
      mul_a = AW'(p);
      mul_b = OPB_W'(ONE_Q24 - gain);
    end
  end

  assign mul_start = cmd.mul_rate | cmd.pred | cmd.mul_corr | cmd.corr;

  skaf_mul #(.A_W(AW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (stat.mul_done),
    .prod  (prod)
  );

  assign div_num = NUM_W'({p, {FRAC_W{1'b0}}}) + NUM_W'(s[DEN_W-1:1]);

  skaf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (s),
    .done  (stat.div_done),
    .quo   (quo)
  );

  assign rnd32 = prod + (PW'(1) << (OPB_W - 1));
  assign rnd24 = prod + (PW'(1) << (FRAC_W - 1));

  assign p_sum   = {1'b0, cov} + {1'b0, rnd32[2*OPB_W-1:OPB_W]};
  assign p_new   = p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
  assign cov_new = (|rnd24[PW-1:FRAC_W+VAR_W]) ? '1 : rnd24[FRAC_W+VAR_W-1:FRAC_W];

  assign sub     = cmd.pred ? rate[DW-1] : y[DW-1];
  assign est_x   = SW'(est);
  assign tmp_s   = $signed({2'b00, tmp});
  assign est_sum = sub ? (est_x - tmp_s) : (est_x + tmp_s);
  assign y_diff  = SW'(meas) - SW'(est);

  assign gain_new = (s == '0) ? '0 : ((quo > ONE_Q24) ? ONE_Q24 : quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      cov <= COVARIANCE_RST;
    end else begin
      if (cmd.pred) begin
        est <= mode ? rate : sat_dw(est_sum);
      end else if (cmd.corr) begin
        est <= sat_dw(est_sum);
      end
      if (cmd.cap_cov) begin
        cov <= cov_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meas <= measurement;
      rate <= control_rate;
      dt   <= time_step;
    end
    if (cmd.cap_rate) begin
      tmp <= TW'(rnd32[PW-1:OPB_W]);
    end else if (cmd.cap_corr) begin
      tmp <= rnd24[PW-1:FRAC_W];
    end
    if (cmd.cap_q) begin
      p <= p_new;
    end
    if (cmd.resid) begin
      y <= sat_dw(y_diff);
      s <= {1'b0, p} + {1'b0, measurement_noise};
    end
    if (cmd.cap_gain) begin
      gain <= gain_new;
    end
    if (cmd.load_out) begin
      estimate_out   <= est;
      gain_out       <= gain;
      covariance_out <= cov;
      residual_out   <= y;
    end
  end

endmodule

>>> rtl/core/skaf_ctrl.sv
module skaf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  skaf_pkg::stat_t  stat,
  output skaf_pkg::cmd_t   cmd
);
  import skaf_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'h0001,
    ST_MRATE = 13'h0002,
    ST_WRATE = 13'h0004,
    ST_PRED  = 13'h0008,
    ST_WQ    = 13'h0010,
    ST_RES   = 13'h0020,
    ST_DIV   = 13'h0040,
    ST_WDIV  = 13'h0080,
    ST_MCORR = 13'h0100,
    ST_WCORR = 13'h0200,
    ST_EST   = 13'h0400,
    ST_WCOV  = 13'h0800,
    ST_DONE  = 13'h1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MRATE;
      ST_MRATE: state_next = ST_WRATE;
      ST_WRATE: if (stat.mul_done) state_next = ST_PRED;
      ST_PRED:  state_next = ST_WQ;
      ST_WQ:    if (stat.mul_done) state_next = ST_RES;
      ST_RES:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_WDIV;
      ST_WDIV:  if (stat.div_done) state_next = ST_MCORR;
      ST_MCORR: state_next = ST_WCORR;
      ST_WCORR: if (stat.mul_done) state_next = ST_EST;
      ST_EST:   state_next = ST_WCOV;
      ST_WCOV:  if (stat.mul_done) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load_in   = (state == ST_IDLE) && in_valid;
    cmd.mul_rate  = (state == ST_MRATE);
    cmd.cap_rate  = (state == ST_WRATE) && stat.mul_done;
    cmd.pred      = (state == ST_PRED);
    cmd.cap_q     = (state == ST_WQ) && stat.mul_done;
    cmd.resid     = (state == ST_RES);
    cmd.div_start = (state == ST_DIV);
    cmd.cap_gain  = (state == ST_WDIV) && stat.div_done;
    cmd.mul_corr  = (state == ST_MCORR);
    cmd.cap_corr  = (state == ST_WCORR) && stat.mul_done;
    cmd.corr      = (state == ST_EST);
    cmd.cap_cov   = (state == ST_WCOV) && stat.mul_done;
    cmd.load_out  = (state == ST_DONE) && (!out_valid || out_ready);
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/scalar_kalman_angle_filter.sv
// channel  signals                                         dir  beat
// in       in_valid/in_ready, measurement, control_rate,   in   one sample
//          time_step
// out      out_valid/out_ready, estimate_out, gain_out,    out  one result
//          covariance_out, residual_out
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data        in   one register write
//
// One sample at a time: it runs through the 25-step gain divider and four
// passes through the shared 32x32 multiplier, and the next sample is accepted
// only once its result is loaded into the output register.
// Sync reset: estimate 0, covariance 1.0, registers to defaults.
// A result waiting on out_ready does not block the next input beat; a second
// result holds the controller until the output register frees.
module scalar_kalman_angle_filter #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        measurement,
  input  logic signed [DATA_WIDTH-1:0]        control_rate,
  input  logic [skaf_pkg::DT_W-1:0]           time_step,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        estimate_out,
  output logic [skaf_pkg::GAIN_W-1:0]         gain_out,
  output logic [skaf_pkg::VAR_W-1:0]          covariance_out,
  output logic signed [DATA_WIDTH-1:0]        residual_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skaf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [skaf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import skaf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  skaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skaf_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .measurement    (measurement),
    .control_rate   (control_rate),
    .time_step      (time_step),
    .estimate_out   (estimate_out),
    .gain_out       (gain_out),
    .covariance_out (covariance_out),
    .residual_out   (residual_out)
  );

endmodule

>>> test/kalman_tb_pkg.sv
package kalman_tb_pkg;

  localparam logic MODE_PITCH = 1'b0;
  localparam logic MODE_YAW   = 1'b1;

  // index with no register behind it; writes must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

endpackage

>>> test/kalman_result_checker.sv
module kalman_result_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [DATA_WIDTH-1:0]     measurement,
  input  logic signed [DATA_WIDTH-1:0]     control_rate,
  input  logic [skaf_pkg::DT_W-1:0]        time_step,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [DATA_WIDTH-1:0]     estimate_out,
  input  logic [skaf_pkg::GAIN_W-1:0]      gain_out,
  input  logic [skaf_pkg::VAR_W-1:0]       covariance_out,
  input  logic signed [DATA_WIDTH-1:0]     residual_out,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [skaf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [skaf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import skaf_pkg::*;
  import kalman_tb_pkg::*;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] estimate;
    logic [GAIN_W-1:0]            gain;
    logic [VAR_W-1:0]             covariance;
    logic signed [DATA_WIDTH-1:0] residual;
  } kf_result_t;

  logic              mode_reg = MODE_PITCH;
  logic [VAR_W-1:0]  q_reg    = PROCESS_NOISE_RST;
  logic [VAR_W-1:0]  r_reg    = MEASUREMENT_NOISE_RST;
  longint            est_state = 0;
  logic [VAR_W-1:0]  cov_state = COVARIANCE_RST;

  kf_result_t expected_results[$];
  int fail_count = 0;

  assign errors = fail_count;

  function automatic longint clamp_signal(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round(a * b / 2^sh), half away from zero
  function automatic longint round_mul(input longint a, input logic [31:0] b, input int sh);
    longint       am;
    logic [127:0] prod;
    am = (a < 0) ? -a : a;
    prod = (128'(am) * 128'(b) + (128'd1 << (sh - 1))) >> sh;
    return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic kf_result_t compute_expected(input logic signed [DATA_WIDTH-1:0] meas,
                                                  input logic signed [DATA_WIDTH-1:0] rate,
                                                  input logic [DT_W-1:0] dt);
    kf_result_t res;
    longint     est;
    longint     resid;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] g;
    if (mode_reg == MODE_PITCH) est = clamp_signal(est_state + round_mul(rate, dt, 32));
    else est = rate;

    p = 64'(cov_state) + ((64'(q_reg) * 64'(dt) + 64'h8000_0000) >> 32);
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;

    resid = clamp_signal(longint'(meas) - est);

    s = p + 64'(r_reg);
    if (s == 0) g = 0;
    else g = ((p << 24) + (s >> 1)) / s;
    if (g > 64'(ONE_Q24)) g = 64'(ONE_Q24);

    est = clamp_signal(est + round_mul(resid, g[31:0], 24));
    p = (p * (64'(ONE_Q24) - g) + 64'd8388608) >> 24;
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;

    est_state = est;
    cov_state = p[VAR_W-1:0];

    res.estimate   = est[DATA_WIDTH-1:0];
    res.gain       = g[GAIN_W-1:0];
    res.covariance = p[VAR_W-1:0];
    res.residual   = resid[DATA_WIDTH-1:0];
    return res;
  endfunction

  task automatic report_failure(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    kf_result_t want;
    if (rst) begin
      mode_reg  = MODE_PITCH;
      q_reg     = PROCESS_NOISE_RST;
      r_reg     = MEASUREMENT_NOISE_RST;
      est_state = 0;
      cov_state = COVARIANCE_RST;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:              mode_reg = cfg_data[0];
          REG_PROCESS_NOISE:     q_reg = cfg_data;
          REG_MEASUREMENT_NOISE: r_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(compute_expected(measurement, control_rate, time_step));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_failure("result beat with no sample pending");
        end else begin
          want = expected_results.pop_front();
          if (estimate_out !== want.estimate)
            report_failure($sformatf("estimate_out expected %0d got %0d",
                                     want.estimate, estimate_out));
          if (gain_out !== want.gain)
            report_failure($sformatf("gain_out expected %0d got %0d", want.gain, gain_out));
          if (covariance_out !== want.covariance)
            report_failure($sformatf("covariance_out expected %0d got %0d",
                                     want.covariance, covariance_out));
          if (residual_out !== want.residual)
            report_failure($sformatf("residual_out expected %0d got %0d",
                                     want.residual, residual_out));
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

>>> test/tb_scalar_kalman_angle_filter.sv
module tb_scalar_kalman_angle_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import skaf_pkg::*;
  import kalman_tb_pkg::*;

  localparam int DW              = 32;
  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE          = 60;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 155;

  localparam logic signed [DW-1:0] SIG_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SIG_MIN  = {1'b1, {(DW-1){1'b0}}};
  localparam logic [31:0]          WORD_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic signed [DW-1:0]     measurement  = '0;
  logic signed [DW-1:0]     control_rate = '0;
  logic [DT_W-1:0]          time_step    = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic signed [DW-1:0]     estimate_out;
  logic [GAIN_W-1:0]        gain_out;
  logic [VAR_W-1:0]         covariance_out;
  logic signed [DW-1:0]     residual_out;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index    = '0;
  logic [CFG_DATA_W-1:0]    cfg_data     = '0;

  int errors;
  int outstanding;
  int quiet = 0;
  int samples_sent = 0;
  int writes_done = 0;
  int settings_used = 1;
  bit steady = 1'b0;
  logic signed [DW-1:0] track = '0;

  scalar_kalman_angle_filter #(.DATA_WIDTH(DW)) dut (.*);

  kalman_result_checker #(.DATA_WIDTH(DW)) checker_i (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // result side: random stall per beat, none while steady
  initial begin : drain
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_sample(input logic signed [DW-1:0] meas, input logic signed [DW-1:0] rate,
                             input logic [DT_W-1:0] dt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    measurement  <= meas;
    control_rate <= rate;
    time_step    <= dt;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    writes_done++;
  endtask

  task automatic set_registers(input logic [31:0] mode_word, input logic [31:0] q,
                               input logic [31:0] r, input bit poke_unused);
    write_reg(REG_MODE, mode_word);
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASUREMENT_NOISE, r);
    if (poke_unused) write_reg(REG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] pick_signal(input logic signed [DW-1:0] center);
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = SIG_MAX;
          1:       v = SIG_MIN;
          2:       v = '0;
          default: v = -1;
        endcase
      end
      1, 2:    v = $urandom();
      default: v = center + ($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_dt();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? WORD_MAX : 32'd0;
      1:       return $urandom();
      default: return $urandom_range(1 << 21, 1 << 24);
    endcase
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return WORD_MAX;
      2:       return $urandom();
      default: return $urandom_range(0, 1 << 25);
    endcase
  endfunction

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // power-on registers, saturation of prediction and residual
    send_sample('0, '0, '0);
    send_sample(SIG_MAX, SIG_MAX, WORD_MAX);
    send_sample(SIG_MAX, SIG_MAX, WORD_MAX);
    send_sample(SIG_MIN, SIG_MIN, WORD_MAX);
    send_sample(SIG_MAX, SIG_MIN, WORD_MAX);
    send_sample(-1, 1, 32'd1);
    in_valid <= 1'b0;
    wait_idle();

    // yaw, process noise at max, no measurement noise: gain of one while P is nonzero; junk high bits in mode word
    set_registers(WORD_MAX, WORD_MAX, 32'd0, 1'b1);
    send_sample(SIG_MIN, SIG_MAX, WORD_MAX);
    send_sample(SIG_MAX, SIG_MIN, 32'd0);
    send_sample('0, '0, WORD_MAX);
    in_valid <= 1'b0;
    wait_idle();

    // pitch with no noise at all: P collapses to zero, then P+R is zero
    set_registers(32'hFFFF_FFFE, 32'd0, 32'd0, 1'b0);
    send_sample(32'sd12345, '0, '0);
    send_sample(SIG_MAX, SIG_MAX, WORD_MAX);
    send_sample(-5, 7, '0);
    send_sample('0, '0, '0);
    in_valid <= 1'b0;
    wait_idle();

    set_registers({31'd0, MODE_PITCH}, WORD_MAX, WORD_MAX, 1'b0);
    send_sample(SIG_MIN, SIG_MAX, WORD_MAX);
    send_sample(SIG_MAX, SIG_MIN, WORD_MAX);
    send_sample(32'sd65536, 32'sd65536, 32'd4294967);
    in_valid <= 1'b0;
    wait_idle();

    set_registers({31'd0, MODE_YAW}, 32'd1, 32'd1, 1'b0);
    send_sample(32'sd100, -32'sd100, 32'd1);
    send_sample(-32'sd100, 32'sd100, 32'd1);
    in_valid <= 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      steady = (ph % 3 == 2);
      set_registers($urandom(), pick_noise(), pick_noise(), $urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        track = track + ($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        send_sample(pick_signal(track), pick_signal('0), pick_dt());
      end
      in_valid <= 1'b0;
    end
    steady = 1'b0;

    wait_idle();
    $display("Covered %0d samples and %0d register writes over %0d filter settings,",
             samples_sent, writes_done, settings_used);
    $display("pitch and yaw, with saturation and zero-variance gain cases.");
    if (errors == 0 && outstanding == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> scalar_kalman_angle_filter.f
rtl/core/skaf_pkg.sv
rtl/core/skaf_mul.sv
rtl/core/skaf_div.sv
rtl/core/skaf_dp.sv
rtl/core/skaf_ctrl.sv
rtl/core/scalar_kalman_angle_filter.sv
test/kalman_tb_pkg.sv
test/kalman_result_checker.sv
test/tb_scalar_kalman_angle_filter.sv
